FILE: rtl/core/window_settle_touch_detector_macros.svh
// ---------------------------------------------------------------------------
// window_settle_touch_detector_macros
// assertion macros shared by the checker files of the settle detector
// ---------------------------------------------------------------------------
`ifndef WINDOW_SETTLE_TOUCH_DETECTOR_MACROS_SVH
`define WINDOW_SETTLE_TOUCH_DETECTOR_MACROS_SVH

// assertion sampled on the rising clock, off while reset is high
`define WSTD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// assertion sampled on the rising clock, also active during reset
`define WSTD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/wstd_pkg.sv
// ---------------------------------------------------------------------------
// wstd_pkg
// types and constants of the window settle touch detector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wstd_pkg;

   localparam int WINDOW_MAX_DEF = 64;
   localparam int SAMPLE_W       = 32;
   localparam int WLEN_W         = 7;
   localparam int TOL_W          = 20;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [WLEN_W-1:0]   WLEN_RST   = 7'd8;
   localparam logic [TOL_W-1:0]    TOL_RST    = 20'd100;
   localparam logic [SAMPLE_W-1:0] TARGET_RST = 32'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LEN = 2'd0,
      CSR_TOLERANCE  = 2'd1,
      CSR_TARGET_POS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] position;
      logic                       first_sample;
   } req_type;

   typedef struct packed {
      logic                       settled;
      logic                       touched;
      logic signed [SAMPLE_W-1:0] average;
   } rsp_type;

endpackage

FILE: rtl/core/wstd_ring.sv
// ---------------------------------------------------------------------------
// wstd_ring
// sample ring memory, one write port and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstd_ring
   import wstd_pkg::*;
#(
   parameter int DEPTH  = WINDOW_MAX_DEF,
   parameter int ADDR_W = $clog2(WINDOW_MAX_DEF)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/wstd_div.sv
// ---------------------------------------------------------------------------
// wstd_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstd_div
   import wstd_pkg::*;
#(
   parameter int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX_DEF + 1),
   parameter int LEN_W = $clog2(WINDOW_MAX_DEF + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   input  logic [LEN_W-1:0]           divisor,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] dq_ff, dq_in;
   logic [LEN_W-1:0] den_ff, den_in;

   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   trial_sub;
   logic             fits;
   logic [SUM_W-1:0] quo_full;

   assign trial     = {rem_ff, dq_ff[SUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[SUM_W-1];
         rem_in  = '0;
         dq_in   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
         dq_in  = {dq_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      den_ff <= den_in;
   end

   assign quo_full = neg_ff ? (~dq_ff + 1'b1) : dq_ff;
   assign quotient = quo_full[SAMPLE_W-1:0];
   assign done     = done_ff;

endmodule

FILE: rtl/core/window_settle_touch_detector.sv
// ---------------------------------------------------------------------------
// window_settle_touch_detector
// moving window settle and touch detector for position feedback samples
// ---------------------------------------------------------------------------
// Each item stores one sample in a WINDOW_MAX deep ring and returns one
// result. Until the window holds L samples (L = window_len limited to
// 1..WINDOW_MAX) the result is all zero. With a full window the ring is
// walked once through its single read port to sum the L newest samples, the
// sum is divided by L in a divider that makes one quotient bit per cycle
// (32 + clog2(WINDOW_MAX+1) bits, 39 at the default), the ring is walked
// again to check each sample against the average, and the average is then
// compared with the target position for the touched flag. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is taken in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_settle_touch_detector
   import wstd_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = SAMPLE_W + LEN_W;
   localparam int CMP_W = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIVIDE,
      ST_CHECK,
      ST_TOUCH,
      ST_RESPOND
   } state_type;

   // configuration
   logic [WLEN_W-1:0]          wlen_ff;
   logic [TOL_W-1:0]           tol_ff;
   logic signed [SAMPLE_W-1:0] target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff   <= WLEN_RST;
         tol_ff    <= TOL_RST;
         target_ff <= TARGET_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LEN: wlen_ff   <= csr_wdata[WLEN_W-1:0];
            CSR_TOLERANCE:  tol_ff    <= csr_wdata[TOL_W-1:0];
            CSR_TARGET_POS: target_ff <= csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective window length
   logic [CMP_W-1:0] wlen_ext;
   logic [LEN_W-1:0] eff_len;

   assign wlen_ext = CMP_W'(wlen_ff);

   always_comb begin
      if (wlen_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (wlen_ext > CMP_W'(WINDOW_MAX)) begin
         eff_len = LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = wlen_ext[LEN_W-1:0];
      end
   end

   // control and datapath registers
   state_type                  state_ff, state_in;
   logic [PTR_W-1:0]           wp_ff, wp_in;
   logic [LEN_W-1:0]           cnt_ff, cnt_in;
   logic [PTR_W-1:0]           newest_ff, newest_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [LEN_W-1:0]           iss_ff, iss_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] ave_ff, ave_in;
   logic                       settled_ff, settled_in;
   logic                       touched_ff, touched_in;

   logic                       mem_we;
   logic                       rd_issue;
   logic                       div_start;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] div_quo;
   logic [SAMPLE_W-1:0]        rd_data;

   logic [PTR_W-1:0]           wp_base;
   logic [LEN_W-1:0]           cnt_base;
   logic [LEN_W-1:0]           cnt_next;
   logic [PTR_W-1:0]           wp_next;
   logic [PTR_W-1:0]           rd_ptr_dec;
   logic                       walk_done;

   assign wp_base    = req_data.first_sample ? '0 : wp_ff;
   assign cnt_base   = req_data.first_sample ? '0 : cnt_ff;
   assign cnt_next   = (cnt_base == LEN_W'(WINDOW_MAX)) ? cnt_base : cnt_base + 1'b1;
   assign wp_next    = (wp_base == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_base + 1'b1;
   assign rd_ptr_dec = (rd_ptr_ff == '0) ? PTR_W'(WINDOW_MAX - 1) : rd_ptr_ff - 1'b1;
   assign walk_done  = (iss_ff == eff_len) && !rd_vld_ff;

   // shared deviation compare: against a ring sample or the target
   logic [SAMPLE_W-1:0] cmp_op;
   logic [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]   mag;
   logic                exceed;

   assign cmp_op = (state_ff == ST_TOUCH) ? target_ff : rd_data;
   assign diff   = {ave_ff[SAMPLE_W-1], ave_ff} - {cmp_op[SAMPLE_W-1], cmp_op};
   assign mag    = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
   assign exceed = mag > (SAMPLE_W + 1)'(tol_ff);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      newest_in    = newest_ff;
      rd_ptr_in    = rd_ptr_ff;
      iss_in       = iss_ff;
      sum_in       = sum_ff;
      ave_in       = ave_ff;
      settled_in   = settled_ff;
      touched_in   = touched_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      rd_issue     = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mem_we    = 1'b1;
               wp_in     = wp_next;
               cnt_in    = cnt_next;
               newest_in = wp_base;
               rd_ptr_in = wp_base;
               iss_in    = '0;
               sum_in    = '0;
               if (cnt_next < eff_len) begin
                  settled_in = 1'b0;
                  touched_in = 1'b0;
                  ave_in     = '0;
                  state_in   = ST_RESPOND;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (iss_ff != eff_len) begin
               rd_issue  = 1'b1;
               rd_ptr_in = rd_ptr_dec;
               iss_in    = iss_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + {{LEN_W{rd_data[SAMPLE_W-1]}}, rd_data};
            end
            if (walk_done) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               ave_in     = div_quo;
               settled_in = 1'b1;
               rd_ptr_in  = newest_ff;
               iss_in     = '0;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (iss_ff != eff_len) begin
               rd_issue  = 1'b1;
               rd_ptr_in = rd_ptr_dec;
               iss_in    = iss_ff + 1'b1;
            end
            if (rd_vld_ff && exceed) begin
               settled_in = 1'b0;
            end
            if (walk_done) begin
               state_in = ST_TOUCH;
            end
         end
         ST_TOUCH: begin
            touched_in = settled_ff && exceed;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.settled = settled_ff;
               rsp_data_in.touched = touched_ff;
               rsp_data_in.average = ave_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_vld_in = rd_issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         iss_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      newest_ff   <= newest_in;
      rd_ptr_ff   <= rd_ptr_in;
      sum_ff      <= sum_in;
      ave_ff      <= ave_in;
      settled_ff  <= settled_in;
      touched_ff  <= touched_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   wstd_ring #(
      .DEPTH  (WINDOW_MAX),
      .ADDR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wp_base),
      .wr_data (req_data.position),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   wstd_div #(
      .SUM_W (SUM_W),
      .LEN_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (eff_len),
      .done     (div_done),
      .quotient (div_quo)
   );

endmodule

FILE: rtl/core/wstd_checker.sv
// ---------------------------------------------------------------------------
// wstd_checker
// port level checks of the window settle touch detector
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "window_settle_touch_detector_macros.svh"

module wstd_checker
   import wstd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `WSTD_ASSERT_RST(a_rsp_idle_after_reset, reset |=> !rsp_valid, "result valid after reset")

   `WSTD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   `WSTD_ASSERT(a_touch_needs_settle, rsp_valid && rsp_data.touched |-> rsp_data.settled, "touched without settled")

   `WSTD_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "second item taken while busy")

endmodule

bind window_settle_touch_detector wstd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
